>>> sv/bba_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and types for the bitmap block allocator.
// No dependencies; used by bitmap_block_allocator.
package bba_pkg;

    // Geometry of the managed space
    localparam int NUM_BLOCKS  = 4096;
    localparam int BLOCK_BYTES = 4096;
    localparam int WORD_BITS   = 32;
    localparam int MAP_WORDS   = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;

    localparam int BLK_W   = $clog2(NUM_BLOCKS);   // block index
    localparam int BIT_W   = $clog2(WORD_BITS);    // bit within a map row
    localparam int WIDX_W  = $clog2(MAP_WORDS);    // map row index
    localparam int BSHIFT  = $clog2(BLOCK_BYTES);  // byte address -> block
    localparam int ADDR_W  = 32;
    localparam int CNT_W   = 13;                   // counts, totals, config
    localparam int RNG_W   = ADDR_W + 1 - BSHIFT;  // rounded-up block numbers

    // Register map
    localparam int          PADDR_W           = 3;
    localparam int          PDATA_W           = 32;
    localparam logic [0:0]  REG_BLOCKS_IN_USE = 1'b0;
    localparam logic [CNT_W-1:0] CFG_RESET    = CNT_W'(4096);

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_FREE    = 2'd1,
        OP_RELEASE = 2'd2,
        OP_RESERVE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_FREE  = 2'd1,
        ST_NO_RUN   = 2'd2,
        ST_ZERO_CNT = 2'd3
    } t_status;

endpackage

>>> sv/bitmap_block_allocator.sv
`timescale 1ns / 1ps
// Bitmap block allocator: first-fit run search, run free, region release/reserve.
// Depends on bba_pkg.
//
// One request word at a time. The bitmap (one bit per block, 1 = used) sits in a
// single-port-write map memory of bba_pkg::MAP_WORDS rows of 32 bits, read one row
// per cycle. A shared row evaluator finds free-bit runs during the allocate scan and
// builds the set/clear mask during marking. Allocate reads rows in S_SCAN (up to
// blocks_in_use/32 rows rounded up, 128 at most) to find the run, then marks it
// through S_SETUP and S_MARK; a scan that finds no run goes to S_DONE. Free, release
// and reserve go through S_SETUP and S_MARK to S_DONE; zero count and nothing free go
// straight to S_DONE, and a range that starts outside the map or is empty goes from
// S_SETUP to S_DONE. The next request word is taken as soon as the result word is in
// the output register, even if the sink has not taken it yet. After reset every row
// reads as all used through per-row valid flags, so there is no clearing pass. The
// user must write blocks_in_use over the APB port only while the block is idle; the
// block itself does not enforce this.
module bitmap_block_allocator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request channel
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [1:0]                    i_operation,
    input  logic [bba_pkg::ADDR_W-1:0]    i_address,
    input  logic [bba_pkg::CNT_W-1:0]     i_block_count,
    input  logic [bba_pkg::ADDR_W-1:0]    i_region_bytes,
    // result channel
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [bba_pkg::ADDR_W-1:0]    o_result_address,
    output logic [1:0]                    o_status,
    output logic [bba_pkg::CNT_W-1:0]     o_free_count,
    // config port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bba_pkg::PADDR_W-1:0]   paddr,
    input  logic [bba_pkg::PDATA_W-1:0]   pwdata,
    output logic [bba_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int W   = bba_pkg::WORD_BITS;
    localparam int BW  = bba_pkg::BIT_W;
    localparam int XW  = bba_pkg::WIDX_W;
    localparam int KW  = bba_pkg::CNT_W;
    localparam int LW  = bba_pkg::BLK_W;
    localparam int RW  = bba_pkg::RNG_W;
    localparam int AW  = bba_pkg::ADDR_W;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_SETUP = 5'b00100,
        S_MARK  = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    t_state                r_state,  n_state;
    logic [KW-1:0]         r_cfg;
    logic [KW-1:0]         r_free,   n_free;
    logic [KW-1:0]         r_count,  n_count;   // allocate/free block count
    logic [RW-1:0]         r_start,  n_start;   // first block of range to touch
    logic [RW-1:0]         r_len,    n_len;     // blocks in range
    logic                  r_make_used, n_make_used;
    bba_pkg::t_status      r_status, n_status;
    logic [AW-1:0]         r_res,    n_res;
    logic [XW:0]           r_word,   n_word;    // next row to read
    logic                  r_pend,   n_pend;    // read data valid this cycle
    logic [XW-1:0]         r_pword,  n_pword;   // row of the read data
    logic [KW-1:0]         r_run,    n_run;     // free run carried into the row
    logic [LW-1:0]         r_first,  n_first;   // first block to mark
    logic [LW-1:0]         r_last,   n_last;    // last block to mark
    logic                  r_out_vld, n_out_vld;
    logic [AW-1:0]         r_out_addr;
    logic [1:0]            r_out_status;
    logic [KW-1:0]         r_out_free;
    logic                  out_load;

    // map memory
    logic [W-1:0]          mem [bba_pkg::MAP_WORDS];
    logic [bba_pkg::MAP_WORDS-1:0] r_row_vld;
    logic [W-1:0]          r_rdata;
    logic                  r_rd_vld;
    logic                  rd_en;
    logic [XW-1:0]         rd_idx;
    logic                  wr_en;

    // ---------------------------------------------------------------
    // Config port
    // ---------------------------------------------------------------
    logic cfg_hit;
    assign cfg_hit = (paddr[2:2] == bba_pkg::REG_BLOCKS_IN_USE);
    assign pready  = 1'b1;
    assign prdata  = cfg_hit ? bba_pkg::PDATA_W'(r_cfg) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= bba_pkg::CFG_RESET;
        end else if (psel && penable && pwrite && pready && cfg_hit) begin
            r_cfg <= pwdata[KW-1:0];
        end
    end

    // active total = min(blocks_in_use, NUM_BLOCKS)
    logic [KW-1:0] act_total;
    assign act_total = (r_cfg > KW'(bba_pkg::NUM_BLOCKS)) ? KW'(bba_pkg::NUM_BLOCKS) : r_cfg;

    // ---------------------------------------------------------------
    // Shared row evaluator: works on the row just read
    // ---------------------------------------------------------------
    logic [W-1:0]    row;        // 1 = used
    logic [LW-1:0]   row_base;   // block index of bit 0
    logic [W-1:0]    avail;      // bits below the active total
    logic [W-1:0]    f;          // free and usable
    logic [BW:0]     p_lo;       // free bits from bit 0 up
    logic [BW:0]     q_hi;       // free bits from the top down
    logic [W-1:0]    win;        // window of r_count ones
    logic [W-1:0]    fit;        // window start positions that fit
    logic [BW-1:0]   s_first;
    logic            carry_ok, in_ok, found;
    logic [LW-1:0]   found_blk;
    logic [KW-1:0]   run_next;
    logic            scan_last;
    logic [BW-1:0]   m_lo, m_hi;
    logic [W-1:0]    m_mask, row_new;

    assign row      = r_rd_vld ? r_rdata : '1;   // unwritten rows are all used
    assign row_base = LW'({r_pword, BW'(0)});

    always_comb begin
        for (int i = 0; i < W; i++) begin
            avail[i] = (KW'({r_pword, BW'(i)}) < act_total);
        end
    end
    assign f = ~row & avail;

    always_comb begin
        p_lo = (BW+1)'(W);
        for (int i = W - 1; i >= 0; i--) begin
            if (!f[i]) p_lo = (BW+1)'(i);
        end
    end

    always_comb begin
        q_hi = (BW+1)'(W);
        for (int i = 0; i < W; i++) begin
            if (!f[i]) q_hi = (BW+1)'(W - 1 - i);
        end
    end

    assign win = (r_count >= KW'(W)) ? '1 : ~({W{1'b1}} << r_count[BW-1:0]);

    always_comb begin
        for (int s = 0; s < W; s++) begin
            fit[s] = &((f >> s) | ~win);
        end
    end

    always_comb begin
        s_first = '0;
        for (int s = W - 1; s >= 0; s--) begin
            if (fit[s]) s_first = BW'(s);
        end
    end

    // a run carried in from lower rows wins: it starts earlier
    assign carry_ok  = (({1'b0, r_run} + (KW+1)'(p_lo)) >= {1'b0, r_count});
    assign in_ok     = (r_count <= KW'(W)) && (|fit);
    assign found     = carry_ok || in_ok;
    assign found_blk = carry_ok ? (row_base - LW'(r_run)) : (row_base + LW'(s_first));
    assign run_next  = (&f) ? (r_run + KW'(W)) : KW'(q_hi);
    assign scan_last = (KW'({({1'b0, r_pword} + (XW+1)'(1)), BW'(0)}) >= act_total);

    // mark mask: bits lo..hi of the row
    assign m_lo    = (r_pword == r_first[LW-1:BW]) ? r_first[BW-1:0] : '0;
    assign m_hi    = (r_pword == r_last[LW-1:BW])  ? r_last[BW-1:0]  : '1;
    assign m_mask  = ({W{1'b1}} << m_lo) & ({W{1'b1}} >> (BW'(W - 1) - m_hi));
    assign row_new = r_make_used ? (row | m_mask) : (row & ~m_mask);

    // ---------------------------------------------------------------
    // Range setup: clip to the map, move the free count
    // ---------------------------------------------------------------
    logic            s_in_map, do_mark;
    logic [RW:0]     s_end;
    logic [LW:0]     s_end_c;
    logic [KW-1:0]   s_n;
    logic [KW:0]     inc_sum;
    logic [KW-1:0]   free_upd;

    assign s_in_map = (r_start < RW'(bba_pkg::NUM_BLOCKS));
    assign do_mark  = s_in_map && (r_len != '0);
    assign s_end    = {1'b0, r_start} + {1'b0, r_len};
    assign s_end_c  = (s_end > (RW+1)'(bba_pkg::NUM_BLOCKS)) ? (LW+1)'(bba_pkg::NUM_BLOCKS)
                                                             : s_end[LW:0];
    assign s_n      = KW'(s_end_c - (LW+1)'(r_start));
    assign inc_sum  = {1'b0, r_free} + {1'b0, s_n};

    // per-block saturation collapses to one clamp for the whole range
    always_comb begin
        if (r_make_used) begin
            free_upd = (r_free >= s_n) ? (r_free - s_n) : '0;
        end else if (r_free >= act_total) begin
            free_upd = r_free;
        end else begin
            free_upd = (inc_sum > {1'b0, act_total}) ? act_total : inc_sum[KW-1:0];
        end
    end

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    logic in_acc;
    assign o_ready = (r_state == S_IDLE);
    assign in_acc  = i_valid && o_ready;

    always_comb begin
        n_state     = r_state;
        n_free      = r_free;
        n_count     = r_count;
        n_start     = r_start;
        n_len       = r_len;
        n_make_used = r_make_used;
        n_status    = r_status;
        n_res       = r_res;
        n_word      = r_word;
        n_pend      = 1'b0;
        n_pword     = r_pword;
        n_run       = r_run;
        n_first     = r_first;
        n_last      = r_last;
        rd_en       = 1'b0;
        rd_idx      = r_word[XW-1:0];
        wr_en       = 1'b0;
        out_load    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_count     = i_block_count;
                    n_res       = '0;
                    n_status    = bba_pkg::ST_OK;
                    n_make_used = (i_operation == bba_pkg::OP_ALLOC) ||
                                  (i_operation == bba_pkg::OP_RESERVE);
                    n_word      = '0;
                    n_run       = '0;
                    unique case (i_operation)
                        bba_pkg::OP_ALLOC: begin
                            if (i_block_count == '0) begin
                                n_status = bba_pkg::ST_ZERO_CNT;
                                n_state  = S_DONE;
                            end else if (r_free == '0) begin
                                n_status = bba_pkg::ST_NO_FREE;
                                n_state  = S_DONE;
                            end else begin
                                n_state  = S_SCAN;
                            end
                        end
                        bba_pkg::OP_FREE: begin
                            if (i_block_count == '0) begin
                                n_status = bba_pkg::ST_ZERO_CNT;
                                n_state  = S_DONE;
                            end else begin
                                n_start  = RW'(i_address >> bba_pkg::BSHIFT);
                                n_len    = RW'(i_block_count);
                                n_state  = S_SETUP;
                            end
                        end
                        default: begin
                            // release / reserve: start and size rounded up
                            n_start = RW'(({1'b0, i_address} +
                                           (AW+1)'(bba_pkg::BLOCK_BYTES - 1)) >> bba_pkg::BSHIFT);
                            n_len   = RW'(({1'b0, i_region_bytes} +
                                           (AW+1)'(bba_pkg::BLOCK_BYTES - 1)) >> bba_pkg::BSHIFT);
                            n_state = S_SETUP;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                if (r_word < (XW+1)'(bba_pkg::MAP_WORDS)) begin
                    rd_en   = 1'b1;
                    n_word  = r_word + (XW+1)'(1);
                    n_pend  = 1'b1;
                    n_pword = r_word[XW-1:0];
                end
                if (r_pend) begin
                    if (found) begin
                        n_start = RW'(found_blk);
                        n_len   = RW'(r_count);
                        n_res   = AW'(found_blk) << bba_pkg::BSHIFT;
                        n_pend  = 1'b0;
                        n_state = S_SETUP;
                    end else if (scan_last) begin
                        n_status = bba_pkg::ST_NO_RUN;
                        n_pend   = 1'b0;
                        n_state  = S_DONE;
                    end else begin
                        n_run = run_next;
                    end
                end
            end

            S_SETUP: begin
                if (do_mark) begin
                    n_free  = free_upd;
                    n_first = r_start[LW-1:0];
                    n_last  = LW'(s_end_c - (LW+1)'(1));
                    n_word  = (XW+1)'(r_start[LW-1:BW]);
                    n_state = S_MARK;
                end else begin
                    n_state = S_DONE;
                end
            end

            S_MARK: begin
                if (r_word <= {1'b0, r_last[LW-1:BW]}) begin
                    rd_en   = 1'b1;
                    n_word  = r_word + (XW+1)'(1);
                    n_pend  = 1'b1;
                    n_pword = r_word[XW-1:0];
                end
                if (r_pend) begin
                    wr_en = 1'b1;
                    if (r_pword == r_last[LW-1:BW]) begin
                        n_pend  = 1'b0;
                        n_state = S_DONE;
                    end
                end
            end

            S_DONE: begin
                if (!r_out_vld || i_ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (out_load) begin
            n_out_vld = 1'b1;
        end else if (i_ready) begin
            n_out_vld = 1'b0;
        end else begin
            n_out_vld = r_out_vld;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_free    <= '0;
            r_pend    <= 1'b0;
            r_out_vld <= 1'b0;
            r_row_vld <= '0;
        end else begin
            r_state   <= n_state;
            r_free    <= n_free;
            r_pend    <= n_pend;
            r_out_vld <= n_out_vld;
            if (wr_en) r_row_vld[r_pword] <= 1'b1;
        end
    end

    // request payload and walk pointers
    always_ff @(posedge i_clk) begin
        r_count     <= n_count;
        r_start     <= n_start;
        r_len       <= n_len;
        r_make_used <= n_make_used;
        r_status    <= n_status;
        r_res       <= n_res;
        r_word      <= n_word;
        r_pword     <= n_pword;
        r_run       <= n_run;
        r_first     <= n_first;
        r_last      <= n_last;
        if (out_load) begin
            r_out_addr   <= r_res;
            r_out_status <= r_status;
            r_out_free   <= r_free;
        end
    end

    // map memory: one write, one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) mem[r_pword] <= row_new;
        if (rd_en) begin
            r_rdata  <= mem[rd_idx];
            r_rd_vld <= r_row_vld[rd_idx];
        end
    end

    assign o_valid          = r_out_vld;
    assign o_result_address = r_out_addr;
    assign o_status         = r_out_status;
    assign o_free_count     = r_out_free;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("request taken but block stayed ready");

    a_no_free_means_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == bba_pkg::ST_NO_FREE)) |-> (o_free_count == '0))
        else $error("nothing-free result with nonzero free count");

    a_fail_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != bba_pkg::ST_OK)) |-> (o_result_address == '0))
        else $error("failed request returned an address");

    a_free_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |-> (r_free <= KW'(bba_pkg::NUM_BLOCKS)))
        else $error("free count above map size");

endmodule

>>> test/bitmap_block_allocator_test.sv
`timescale 1ns / 1ps
// Self-checking bench for bitmap_block_allocator: request words go in, result words are
// compared against an in-bench bitmap/free-count predictor. Depends on bba_pkg and the RTL.
module bitmap_block_allocator_test;

    localparam int ADDR_W      = bba_pkg::ADDR_W;
    localparam int CNT_W       = bba_pkg::CNT_W;
    localparam int NUM_BLOCKS  = bba_pkg::NUM_BLOCKS;
    localparam int BLOCK_BYTES = bba_pkg::BLOCK_BYTES;
    localparam int BSHIFT      = bba_pkg::BSHIFT;
    localparam int PADDR_W     = bba_pkg::PADDR_W;
    localparam int PDATA_W     = bba_pkg::PDATA_W;
    localparam logic [CNT_W-1:0] CFG_RESET = bba_pkg::CFG_RESET;

    typedef longint unsigned t_u64;

    // One predicted result word
    typedef struct {
        logic [ADDR_W-1:0] addr;
        bba_pkg::t_status  status;
        logic [CNT_W-1:0]  free;
    } t_alloc_result;

    // A run handed out by a successful allocate, kept so it can be freed later
    typedef struct {
        int unsigned first;
        int unsigned len;
    } t_span;

    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 i_valid        = 1'b0;
    logic                 o_ready;
    logic [1:0]           i_operation    = bba_pkg::OP_ALLOC;
    logic [ADDR_W-1:0]    i_address      = '0;
    logic [CNT_W-1:0]     i_block_count  = '0;
    logic [ADDR_W-1:0]    i_region_bytes = '0;
    logic                 o_valid;
    logic                 i_ready        = 1'b1;
    logic [ADDR_W-1:0]    o_result_address;
    logic [1:0]           o_status;
    logic [CNT_W-1:0]     o_free_count;
    logic                 psel           = 1'b0;
    logic                 penable        = 1'b0;
    logic                 pwrite         = 1'b0;
    logic [PADDR_W-1:0]   paddr          = '0;
    logic [PDATA_W-1:0]   pwdata         = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    // Predictor state: bitmap (1 = used), free count, and the block-total register
    logic [NUM_BLOCKS-1:0] used_map    = '1;
    int unsigned           spare_blocks = 0;
    logic [CNT_W-1:0]      total_reg    = CFG_RESET;

    t_alloc_result pending_results[$];
    t_span         live_runs[$];

    int err_count    = 0;
    bit src_idle_on  = 1'b1;
    bit sink_idle_on = 1'b1;

    bitmap_block_allocator dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_operation      (i_operation),
        .i_address        (i_address),
        .i_block_count    (i_block_count),
        .i_region_bytes   (i_region_bytes),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_result_address (o_result_address),
        .o_status         (o_status),
        .o_free_count     (o_free_count),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Searches and count saturation use min(register, map size)
    function automatic int unsigned active_blocks();
        return (total_reg > NUM_BLOCKS) ? NUM_BLOCKS : total_reg;
    endfunction

    function automatic t_u64 round_up_blocks(t_u64 bytes);
        return (bytes + BLOCK_BYTES - 1) / BLOCK_BYTES;
    endfunction

    // Set or clear a block range clipped to the map. The count moves once per block
    // touched, changed or not, and saturates at zero and at the active total.
    function automatic void mark_span(t_u64 first, t_u64 len, bit set_used);
        t_u64        last;
        t_u64        b;
        int unsigned cap;
        cap = active_blocks();
        if (first >= NUM_BLOCKS) return;
        last = first + len;
        if (last > NUM_BLOCKS) last = NUM_BLOCKS;
        for (b = first; b < last; b++) begin
            used_map[b] = set_used;
            if (set_used) begin
                if (spare_blocks > 0) spare_blocks--;
            end else if (spare_blocks < cap) begin
                spare_blocks++;
            end
        end
    endfunction

    // Applies one request word to the predictor and returns the result word it causes
    function automatic t_alloc_result predict_word(bba_pkg::t_op op,
            logic [ADDR_W-1:0] addr, logic [CNT_W-1:0] cnt, logic [ADDR_W-1:0] bytes);
        t_alloc_result res;
        int unsigned   total;
        int unsigned   run;
        int unsigned   b;
        int unsigned   first;
        bit            found;
        res.addr   = '0;
        res.status = bba_pkg::ST_OK;
        total      = active_blocks();
        case (op)
            bba_pkg::OP_ALLOC: begin
                // zero count wins over nothing free
                if (cnt == 0) begin
                    res.status = bba_pkg::ST_ZERO_CNT;
                end else if (spare_blocks == 0) begin
                    res.status = bba_pkg::ST_NO_FREE;
                end else begin
                    run   = 0;
                    found = 1'b0;
                    first = 0;
                    for (b = 0; b < total && !found; b++) begin
                        run = used_map[b] ? 0 : run + 1;
                        if (run == cnt) begin
                            first = b + 1 - cnt;
                            found = 1'b1;
                        end
                    end
                    if (!found) begin
                        res.status = bba_pkg::ST_NO_RUN;
                    end else begin
                        mark_span(first, cnt, 1'b1);
                        res.addr = ADDR_W'(t_u64'(first) * BLOCK_BYTES);
                    end
                end
            end
            bba_pkg::OP_FREE: begin
                if (cnt == 0) res.status = bba_pkg::ST_ZERO_CNT;
                else          mark_span(addr >> BSHIFT, cnt, 1'b0);
            end
            default: begin
                mark_span(round_up_blocks(addr), round_up_blocks(bytes),
                          op == bba_pkg::OP_RESERVE);
            end
        endcase
        res.free = CNT_W'(spare_blocks);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Result side: random backpressure and the checker
    // ------------------------------------------------------------------

    // Ready drops at random while sink idling is on
    initial begin : sink_pacing
        int unsigned hold;
        @(posedge i_clk);
        forever begin
            if (sink_idle_on && $urandom_range(0, 2) == 0) begin
                i_ready <= 1'b0;
                hold = $urandom_range(1, 13);
            end else begin
                i_ready <= 1'b1;
                hold = $urandom_range(1, 24);
            end
            repeat (hold) @(posedge i_clk);
        end
    end

    // Every accepted result word is matched against the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_alloc_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t ns: unexpected result word, expected none, %s %h %0d %0d",
                         $time, "got addr/status/free", o_result_address, o_status,
                         o_free_count);
                err_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_result_address !== want.addr) begin
                    $display("%0t ns: result_address mismatch, expected %h, got %h",
                             $time, want.addr, o_result_address);
                    err_count++;
                end
                if (o_status !== want.status) begin
                    $display("%0t ns: status mismatch, expected %0d, got %0d",
                             $time, want.status, o_status);
                    err_count++;
                end
                if (o_free_count !== want.free) begin
                    $display("%0t ns: free_count mismatch, expected %0d, got %0d",
                             $time, want.free, o_free_count);
                    err_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Sends one request word. Called in the time step of a rising edge; returns in
    // the step of the edge that accepted it, with valid still high so a following
    // call can go back to back.
    task automatic send_word(bba_pkg::t_op op, logic [ADDR_W-1:0] addr,
            logic [CNT_W-1:0] cnt, logic [ADDR_W-1:0] bytes);
        t_alloc_result want;
        int unsigned   gap;
        if (src_idle_on && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            gap = $urandom_range(1, 13);
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_operation    <= op;
        i_address      <= addr;
        i_block_count  <= cnt;
        i_region_bytes <= bytes;
        do @(posedge i_clk); while (!o_ready);
        want = predict_word(op, addr, cnt, bytes);
        pending_results.push_back(want);
        if (op == bba_pkg::OP_ALLOC && want.status == bba_pkg::ST_OK)
            live_runs.push_back('{want.addr >> BSHIFT, cnt});
    endtask

    // Drop valid and wait until every predicted word has come back; the block is idle
    // afterwards since every request gives exactly one result.
    task automatic flush_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    // One APB transfer to the block-total register: setup, access, then idle.
    // Reads check prdata against the value given.
    task automatic apb_access(bit is_write, logic [CNT_W-1:0] value);
        logic [PDATA_W-1:0] seen;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= PADDR_W'({bba_pkg::REG_BLOCKS_IN_USE, 2'b00});
        // upper data bits are junk on writes; only 13 bits are stored
        pwdata  <= is_write ? {(PDATA_W - CNT_W)'($urandom), value} : '0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        seen     = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (is_write) begin
            total_reg = value;
        end else if (seen !== PDATA_W'(value)) begin
            $display("%0t ns: blocks_in_use readback mismatch, expected %h, got %h",
                     $time, PDATA_W'(value), seen);
            err_count++;
        end
    endtask

    task automatic set_block_total(logic [CNT_W-1:0] value);
        apb_access(1'b1, value);
        apb_access(1'b0, value);
    endtask

    // Release or reserve a block-aligned region given with byte slack so rounding
    // lands on the intended blocks; now and then the start runs past the map.
    task automatic send_span(bba_pkg::t_op op, int unsigned total, int unsigned max_len);
        int unsigned blk;
        int unsigned len;
        int unsigned off;
        logic [ADDR_W-1:0] bytes;
        blk = $urandom_range(0, ((total > 0) ? total : NUM_BLOCKS) - 1);
        if ($urandom_range(0, 7) == 0) blk = $urandom_range(0, NUM_BLOCKS + 63);
        off   = (blk != 0) ? $urandom_range(0, BLOCK_BYTES - 1) : 0;
        len   = $urandom_range(0, max_len);
        bytes = (len != 0) ? ADDR_W'(len * BLOCK_BYTES - $urandom_range(0, BLOCK_BYTES - 1))
                           : '0;
        send_word(op, ADDR_W'(blk * BLOCK_BYTES - off), CNT_W'($urandom_range(0, 4096)),
                  bytes);
    endtask

    // Mostly well-formed traffic: allocations, frees of live runs, aligned region
    // release/reserve. The rest is zero counts and fully random words.
    task automatic send_random_word();
        int unsigned pick;
        int unsigned sz;
        int unsigned idx;
        t_span       s;
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            sz = $urandom_range(0, 19);
            if (sz < 14)      sz = $urandom_range(1, 8);
            else if (sz < 19) sz = $urandom_range(9, 64);
            else              sz = $urandom_range(65, 4096);
            send_word(bba_pkg::OP_ALLOC, $urandom, CNT_W'(sz), $urandom);
        end else if (pick < 58 && live_runs.size() != 0) begin
            idx = $urandom_range(0, live_runs.size() - 1);
            s   = live_runs[idx];
            live_runs.delete(idx);
            // occasionally free a bit more or less than was handed out
            sz  = s.len;
            if ($urandom_range(0, 9) == 0) sz = $urandom_range(1, s.len + 8);
            send_word(bba_pkg::OP_FREE,
                      ADDR_W'(s.first * BLOCK_BYTES + $urandom_range(0, 4095)),
                      CNT_W'(sz), $urandom);
        end else if (pick < 75) begin
            send_span(bba_pkg::OP_RELEASE, active_blocks(), 48);
        end else if (pick < 85) begin
            send_span(bba_pkg::OP_RESERVE, active_blocks(), 16);
        end else if (pick < 90) begin
            send_word($urandom_range(0, 1) ? bba_pkg::OP_FREE : bba_pkg::OP_ALLOC,
                      $urandom, '0, $urandom);
        end else begin
            send_word(bba_pkg::t_op'($urandom_range(0, 3)), $urandom,
                      CNT_W'($urandom_range(0, 4096)), $urandom);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Straight out of reset: everything used, count zero, register at its default
    task automatic test_reset_state();
        apb_access(1'b0, CFG_RESET);
        send_word(bba_pkg::OP_ALLOC,   32'h0000_0000, 13'd1,    32'h0);          // nothing free
        send_word(bba_pkg::OP_ALLOC,   32'hFFFF_FFFF, 13'd0,    32'hFFFF_FFFF);  // zero count
        send_word(bba_pkg::OP_FREE,    32'h0000_0000, 13'd0,    32'h0);
        send_word(bba_pkg::OP_RESERVE, 32'h0000_0000, 13'd4096, 32'hFFFF_FFFF);  // stays 0
        flush_results();
    endtask

    // Whole-map release/allocate, saturation, and blocks past the end of the map
    task automatic test_full_span();
        send_word(bba_pkg::OP_RELEASE, 32'h0000_0000, 13'd0,    32'hFFFF_FFFF);
        send_word(bba_pkg::OP_RELEASE, 32'h0000_0000, 13'd0,    32'h0000_1000);  // at total
        send_word(bba_pkg::OP_ALLOC,   32'h0000_0000, 13'd4096, 32'h0);
        send_word(bba_pkg::OP_ALLOC,   32'h0000_0000, 13'd1,    32'h0);
        send_word(bba_pkg::OP_FREE,    32'hFFFF_FFFF, 13'd4096, 32'h0);          // past map
        send_word(bba_pkg::OP_FREE,    32'h00FF_FFFF, 13'd4096, 32'h0);          // one block
        send_word(bba_pkg::OP_ALLOC,   32'h0000_0000, 13'd2,    32'h0);          // no run
        send_word(bba_pkg::OP_ALLOC,   32'h0000_0000, 13'd1,    32'h0);          // last block
        flush_results();
    endtask

    // Byte regions round up at both ends; allocation takes the lowest run that fits
    task automatic test_rounding_first_fit();
        send_word(bba_pkg::OP_RELEASE, 32'h0000_0001, 13'd0, 32'h0000_0001);     // block 1
        send_word(bba_pkg::OP_RELEASE, 32'h0000_3000, 13'd0, 32'h0000_1001);     // blocks 3, 4
        send_word(bba_pkg::OP_RELEASE, 32'h0000_0000, 13'd0, 32'h0000_0000);
        send_word(bba_pkg::OP_ALLOC,   32'h0,         13'd2, 32'h0);
        send_word(bba_pkg::OP_ALLOC,   32'h0,         13'd1, 32'h0);
        send_word(bba_pkg::OP_RESERVE, 32'h0000_A001, 13'd0, 32'h0000_2000);     // in use
        send_word(bba_pkg::OP_FREE,    32'h0000_0FFF, 13'd8, 32'h0);
        send_word(bba_pkg::OP_ALLOC,   32'h0,         13'd8, 32'h0);
        send_word(bba_pkg::OP_RELEASE, 32'hFFFF_FFFF, 13'd0, 32'hFFFF_FFFF);
        flush_results();
    endtask

    // Register extremes: zero total, one block, above the map size
    task automatic test_block_total();
        send_word(bba_pkg::OP_RELEASE, 32'h0, 13'd0, 32'h0004_0000);
        flush_results();
        set_block_total(13'd0);
        send_word(bba_pkg::OP_ALLOC,   32'h0, 13'd1, 32'h0);                     // zero total
        send_word(bba_pkg::OP_RELEASE, 32'h0, 13'd0, 32'h0000_1000);             // capped
        send_word(bba_pkg::OP_RESERVE, 32'h0, 13'd0, 32'h0000_1000);
        flush_results();
        set_block_total(13'd1);
        send_word(bba_pkg::OP_RELEASE, 32'h0, 13'd0, 32'h0000_1000);
        send_word(bba_pkg::OP_ALLOC,   32'h0, 13'd2, 32'h0);
        send_word(bba_pkg::OP_ALLOC,   32'h0, 13'd1, 32'h0);
        flush_results();
        set_block_total(13'h1FFF);                                               // clamps
        send_word(bba_pkg::OP_RELEASE, 32'h0, 13'd0, 32'hFFFF_FFFF);
        send_word(bba_pkg::OP_ALLOC,   32'h0, 13'd4096, 32'h0);
        send_word(bba_pkg::OP_FREE,    32'h0, 13'd4096, 32'h0);
        flush_results();
    endtask

    // Random traffic under one register setting; halfway through the sender holds
    // until every outstanding result has drained.
    task automatic test_random_mix(int unsigned items, logic [CNT_W-1:0] total_cfg);
        int unsigned i;
        set_block_total(total_cfg);
        for (i = 0; i < items; i++) begin
            send_random_word();
            if (i == items / 2) flush_results();
        end
        flush_results();
    endtask

    initial begin : run_tests
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_full_span();
        test_rounding_first_fit();
        test_block_total();

        test_random_mix(400, CFG_RESET);
        test_random_mix(350, CNT_W'($urandom_range(32, 4096)));
        test_random_mix(300, 13'd33);
        test_random_mix(400, 13'd4096);

        // last stretch runs flat out on both sides
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        test_random_mix(300, CNT_W'($urandom_range(1, 4096)));

        // catch any stray result word after the last one expected
        repeat (300) @(posedge i_clk);
        if (err_count == 0)
            $display("bitmap_block_allocator_test: done, clean");
        else
            $display("bitmap_block_allocator_test: done, errors");
        $finish;
    end

    // Slowest correct run is about 10 ms; this leaves several times that
    initial begin : watchdog
        #60_000_000;
        $display("bitmap_block_allocator_test: done, errors");
        $finish;
    end

endmodule

>>> bitmap_block_allocator.f
sv/bba_pkg.sv
sv/bitmap_block_allocator.sv
test/bitmap_block_allocator_test.sv
